// ===== sv/dtf_pkg.sv =====
`timescale 1ns / 1ps
// dtf_pkg: shared types, widths and constants of the degree trig unit
// no dependencies; used by dtf_cos, dtf_div and degree_trig_function_unit

package dtf_pkg;

  // number formats
  localparam int AFB   = 16;   // fraction bits of the angle
  localparam int RFB   = 16;   // fraction bits of the result
  localparam int IW    = 30;   // internal fraction bits
  localparam int OUT_W = 32;

  localparam logic [63:0] ONE_Q  = 64'd1 << IW;
  localparam logic [63:0] HALF_Q = 64'd1 << (IW - 1);

  localparam logic [OUT_W-1:0] OUT_MAX = 32'h7fffffff;
  localparam logic [OUT_W-1:0] OUT_MIN = 32'h80000000;

  // angle reduction
  localparam int ANG_W    = 33;  // angle or angle minus ninety
  localparam int MAG_W    = 32;  // magnitude of that
  localparam int RED_Y_W  = MAG_W - AFB;
  localparam int RED_K    = RED_Y_W + 9;
  localparam int RED_R_W  = RED_K - 7;
  localparam int RED_P_W  = RED_Y_W + RED_R_W;
  localparam int RED_Q_W  = RED_Y_W - 7;
  localparam logic [RED_R_W-1:0] RED_R =
    RED_R_W'(((64'd1 << RED_K) + 64'd359) / 64'd360);
  localparam int FULL_W = AFB + 9;
  localparam int U_W    = AFB + 8;
  localparam logic [FULL_W-1:0] FULL   = FULL_W'(360) << AFB;
  localparam logic [FULL_W-1:0] HALF   = FULL_W'(180) << AFB;
  localparam logic [ANG_W-1:0]  NINETY = ANG_W'(90) << AFB;

  // degrees to radians, round(pi/180 * 2^30)
  localparam int DEG2RAD_W = 25;
  localparam logic [DEG2RAD_W-1:0] DEG2RAD = 25'd18740330;
  localparam int XP_W = U_W + DEG2RAD_W;
  localparam int X_W  = 32;
  localparam int S_W  = 34;

  // series divisors n = 2^sh * b, divided as a shift and a reciprocal multiply
  localparam int SER_N     = 7;
  localparam int SER_SPLIT = 17;
  localparam int SER_K     = 40;
  localparam int SER_R_W   = 41;
  localparam int SER_PP_W  = SER_SPLIT + SER_R_W;
  localparam int SER_PS_W  = 76;
  localparam logic [7:0] SER_HALF [SER_N] = '{8'd91, 8'd66, 8'd45, 8'd28, 8'd15, 8'd6, 8'd1};
  localparam logic [1:0] SER_SH   [SER_N] = '{2'd1, 2'd2, 2'd1, 2'd3, 2'd1, 2'd2, 2'd1};
  localparam logic [SER_R_W-1:0] SER_RECIP [SER_N] = '{
    SER_R_W'(((64'd1 << SER_K) + 64'd90) / 64'd91),
    SER_R_W'(((64'd1 << SER_K) + 64'd32) / 64'd33),
    SER_R_W'(((64'd1 << SER_K) + 64'd44) / 64'd45),
    SER_R_W'(((64'd1 << SER_K) + 64'd6) / 64'd7),
    SER_R_W'(((64'd1 << SER_K) + 64'd14) / 64'd15),
    SER_R_W'(((64'd1 << SER_K) + 64'd2) / 64'd3),
    SER_R_W'(64'd1 << SER_K)
  };
  localparam int QS_W  = 33;
  localparam int T_W   = 31;
  localparam int PP1_W = (QS_W - 16) + T_W;
  localparam int PP0_W = 16 + T_W;
  localparam int P_W   = 34;
  localparam int C_W   = 35;

  localparam int COS_LAT = 9 + 2 * SER_N;

  // division
  localparam int D_W  = C_W - 1;
  localparam int NP_W = D_W + RFB + 1;
  localparam int Q_W  = 33;
  localparam int R_W  = D_W + 1;
  localparam int OV_W = D_W + Q_W;

  localparam int RES_SH = IW - RFB;
  localparam logic [C_W-1:0] RES_RND =
    (RES_SH > 0) ? (C_W'(1) << (RES_SH - 1)) : '0;

  typedef enum logic [1:0] {KIND_COS, KIND_SIN, KIND_TAN, KIND_COT} kind_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             sat;
  } res_t;

  // item data that rides along the divider
  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [OUT_W-1:0] direct;
    logic             dsat;
    logic             dz;
    logic             ovf;
    logic             neg;
    logic             num_pos;
  } side_t;

  // q30 cosine to result format, rounded half away from zero and clipped
  function automatic res_t to_result(input logic signed [C_W-1:0] v);
    logic [C_W-1:0] m;
    logic [C_W-1:0] r;
    logic signed [C_W:0] sv;
    logic [C_W-OUT_W+1:0] hi;
    res_t res;
    m  = v[C_W-1] ? C_W'(-v) : C_W'(v);
    r  = (m + RES_RND) >> RES_SH;
    sv = v[C_W-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    hi = sv[C_W:OUT_W-1];
    if ((&hi) || !(|hi)) begin
      res.value = sv[OUT_W-1:0];
      res.sat   = 1'b0;
    end else begin
      res.value = sv[C_W] ? OUT_MIN : OUT_MAX;
      res.sat   = 1'b1;
    end
    return res;
  endfunction

endpackage

// ===== sv/dtf_cos.sv =====
`timescale 1ns / 1ps
// dtf_cos: pipelined cosine of an angle in degrees, q30 result
// depends on dtf_pkg

module dtf_cos (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [dtf_pkg::ANG_W-1:0]   ang,
  output logic signed [dtf_pkg::C_W-1:0]     cosv
);

  typedef struct packed {
    logic [dtf_pkg::SER_N-1:0][dtf_pkg::QS_W-1:0] q;
    logic                                         neg;
  } ser_carry_t;

  logic                              ang_neg;
  logic [dtf_pkg::MAG_W-1:0]         ang_mag;
  logic                              s1_neg;
  logic [dtf_pkg::MAG_W-1:0]         s1_mag;
  logic [dtf_pkg::RED_P_W-1:0]       s1_prod;
  logic [dtf_pkg::RED_Q_W-1:0]       red_q;
  logic                              s2_neg;
  logic [dtf_pkg::FULL_W-1:0]        s2_ru;
  logic [dtf_pkg::FULL_W-1:0]        u0;
  logic                              fold;
  logic                              s3_neg;
  logic [dtf_pkg::U_W-1:0]           s3_u;
  logic                              s4_neg;
  logic [dtf_pkg::XP_W-1:0]          s4_xp;
  logic                              s5_neg;
  logic [dtf_pkg::X_W-1:0]           s5_x;
  logic                              s6_neg;
  logic [63:0]                       s6_sq;
  logic                              s7_neg;
  logic [dtf_pkg::S_W-1:0]           s7_s;
  logic                              s8_neg;
  logic [dtf_pkg::SER_PP_W-1:0]      s8_pph [dtf_pkg::SER_N];
  logic [dtf_pkg::SER_PP_W-1:0]      s8_ppl [dtf_pkg::SER_N];
  ser_carry_t                        c9;
  ser_carry_t                        ca [dtf_pkg::SER_N];
  ser_carry_t                        cb [dtf_pkg::SER_N-1];
  logic [dtf_pkg::T_W-1:0]           tb [dtf_pkg::SER_N-1];
  logic [dtf_pkg::PP1_W-1:0]         pp1 [dtf_pkg::SER_N];
  logic [dtf_pkg::PP0_W-1:0]         pp0 [dtf_pkg::SER_N];

  // magnitude and quotient estimate for the modulo 360
  assign ang_neg = ang[dtf_pkg::ANG_W-1];
  assign ang_mag = ang_neg ? dtf_pkg::MAG_W'(-ang) : dtf_pkg::MAG_W'(ang);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg  <= ang_neg;
      s1_mag  <= ang_mag;
      s1_prod <= dtf_pkg::RED_P_W'(ang_mag[dtf_pkg::MAG_W-1:dtf_pkg::AFB]) *
                 dtf_pkg::RED_P_W'(dtf_pkg::RED_R);
    end
  end

  // truncating remainder magnitude
  assign red_q = s1_prod[dtf_pkg::RED_K +: dtf_pkg::RED_Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_neg <= s1_neg;
      s2_ru  <= dtf_pkg::FULL_W'(s1_mag -
                ((dtf_pkg::MAG_W'(red_q) * dtf_pkg::MAG_W'(360)) << dtf_pkg::AFB));
    end
  end

  // fold into -180..180, absolute value, then past 180 flips the sign
  assign u0   = (!s2_neg && s2_ru > dtf_pkg::HALF) ? dtf_pkg::FULL - s2_ru : s2_ru;
  assign fold = u0 >= dtf_pkg::HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_neg <= fold;
      s3_u   <= dtf_pkg::U_W'(fold ? u0 - dtf_pkg::HALF : u0);
    end
  end

  // radians, square, and the summed reciprocal products
  always_ff @(posedge clk) begin
    if (en) begin
      s4_neg <= s3_neg;
      s4_xp  <= dtf_pkg::XP_W'(s3_u) * dtf_pkg::XP_W'(dtf_pkg::DEG2RAD);
      s5_neg <= s4_neg;
      s5_x   <= dtf_pkg::X_W'((s4_xp + (dtf_pkg::XP_W'(1) << (dtf_pkg::AFB - 1)))
                >> dtf_pkg::AFB);
      s6_neg <= s5_neg;
      s6_sq  <= 64'(s5_x) * 64'(s5_x);
      s7_neg <= s6_neg;
      s7_s   <= dtf_pkg::S_W'((s6_sq + dtf_pkg::HALF_Q) >> dtf_pkg::IW);
      s8_neg <= s7_neg;
      c9.neg <= s8_neg;
      for (int j = 0; j < dtf_pkg::SER_N; j++) begin
        c9.q[j] <= dtf_pkg::QS_W'(((dtf_pkg::SER_PS_W'(s8_pph[j]) << dtf_pkg::SER_SPLIT) +
                   dtf_pkg::SER_PS_W'(s8_ppl[j])) >> dtf_pkg::SER_K);
      end
    end
  end

  // all seven rounded quotients s/n at once
  for (genvar j = 0; j < dtf_pkg::SER_N; j++) begin : g_quo
    logic [dtf_pkg::S_W-1:0] vs;
    assign vs = dtf_pkg::S_W'(s7_s + dtf_pkg::S_W'(dtf_pkg::SER_HALF[j]))
                >> dtf_pkg::SER_SH[j];
    always_ff @(posedge clk) begin
      if (en) begin
        s8_pph[j] <= dtf_pkg::SER_PP_W'(vs[dtf_pkg::S_W-1:dtf_pkg::SER_SPLIT]) *
                     dtf_pkg::SER_PP_W'(dtf_pkg::SER_RECIP[j]);
        s8_ppl[j] <= dtf_pkg::SER_PP_W'(vs[dtf_pkg::SER_SPLIT-1:0]) *
                     dtf_pkg::SER_PP_W'(dtf_pkg::SER_RECIP[j]);
      end
    end
  end

  // nested series, one multiply stage and one round stage per term
  for (genvar k = 0; k < dtf_pkg::SER_N; k++) begin : g_term
    ser_carry_t              cin;
    logic [dtf_pkg::T_W-1:0] tin;
    logic [dtf_pkg::QS_W-1:0] qk;
    logic [63:0]             psum;
    logic [dtf_pkg::P_W-1:0] p;

    if (k == 0) begin : g_first
      assign cin = c9;
      assign tin = dtf_pkg::T_W'(dtf_pkg::ONE_Q);
    end else begin : g_next
      assign cin = cb[k-1];
      assign tin = tb[k-1];
    end

    assign qk = cin.q[k];

    always_ff @(posedge clk) begin
      if (en) begin
        ca[k]  <= cin;
        pp1[k] <= dtf_pkg::PP1_W'(qk[dtf_pkg::QS_W-1:16]) * dtf_pkg::PP1_W'(tin);
        pp0[k] <= dtf_pkg::PP0_W'(qk[15:0]) * dtf_pkg::PP0_W'(tin);
      end
    end

    assign psum = (64'(pp1[k]) << 16) + 64'(pp0[k]) + dtf_pkg::HALF_Q;
    assign p    = dtf_pkg::P_W'(psum >> dtf_pkg::IW);

    if (k < dtf_pkg::SER_N - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (en) begin
          cb[k] <= ca[k];
          tb[k] <= (p > dtf_pkg::P_W'(dtf_pkg::ONE_Q)) ? '0 :
                   dtf_pkg::T_W'(dtf_pkg::P_W'(dtf_pkg::ONE_Q) - p);
        end
      end
    end else begin : g_last
      logic signed [dtf_pkg::C_W-1:0] c;
      assign c = $signed(dtf_pkg::C_W'(dtf_pkg::ONE_Q)) - $signed(dtf_pkg::C_W'(p));
      always_ff @(posedge clk) begin
        if (en) begin
          cosv <= ca[k].neg ? -c : c;
        end
      end
    end
  end

endmodule

// ===== sv/dtf_div.sv =====
`timescale 1ns / 1ps
// dtf_div: pipelined restoring divider, one quotient bit per stage
// depends on dtf_pkg; item data rides along

module dtf_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  dtf_pkg::side_t              side_in,
  input  logic [dtf_pkg::NP_W-1:0]    num,
  input  logic [dtf_pkg::D_W-1:0]     den,
  output dtf_pkg::side_t              side_out,
  output logic [dtf_pkg::Q_W-1:0]     quo
);

  logic [dtf_pkg::R_W-1:0]  rem  [dtf_pkg::Q_W-1];
  logic [dtf_pkg::NP_W-1:0] nreg [dtf_pkg::Q_W-1];
  logic [dtf_pkg::D_W-1:0]  dreg [dtf_pkg::Q_W-1];
  logic [dtf_pkg::Q_W-1:0]  qreg [dtf_pkg::Q_W];
  dtf_pkg::side_t           sreg [dtf_pkg::Q_W];

  for (genvar i = 0; i < dtf_pkg::Q_W; i++) begin : g_stage
    logic [dtf_pkg::R_W-1:0]  rin;
    logic [dtf_pkg::NP_W-1:0] nin;
    logic [dtf_pkg::D_W-1:0]  din;
    logic [dtf_pkg::Q_W-1:0]  qin;
    dtf_pkg::side_t           sin;
    logic [dtf_pkg::R_W-1:0]  tr;
    logic                     ge;

    if (i == 0) begin : g_first
      assign rin = dtf_pkg::R_W'(num >> dtf_pkg::Q_W);
      assign nin = num;
      assign din = den;
      assign qin = '0;
      assign sin = side_in;
    end else begin : g_next
      assign rin = rem[i-1];
      assign nin = nreg[i-1];
      assign din = dreg[i-1];
      assign qin = qreg[i-1];
      assign sin = sreg[i-1];
    end

    assign tr = {rin[dtf_pkg::R_W-2:0], nin[dtf_pkg::Q_W-1-i]};
    assign ge = tr >= dtf_pkg::R_W'(din);

    always_ff @(posedge clk) begin
      if (rst) begin
        sreg[i] <= '0;
      end else if (en) begin
        sreg[i] <= sin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qreg[i] <= {qin[dtf_pkg::Q_W-2:0], ge};
      end
    end

    if (i < dtf_pkg::Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i]  <= ge ? tr - dtf_pkg::R_W'(din) : tr;
          nreg[i] <= nin;
          dreg[i] <= din;
        end
      end
    end
  end

  assign side_out = sreg[dtf_pkg::Q_W-1];
  assign quo      = qreg[dtf_pkg::Q_W-1];

endmodule

// ===== sv/degree_trig_function_unit.sv =====
`timescale 1ns / 1ps
// degree_trig_function_unit: cosine, sine, tangent, cotangent of degrees
// depends on dtf_pkg, dtf_cos and dtf_div
// throughput: one item per cycle while not stalled; 23 cosine stages, 33 divider stages set the depth
// the pipeline moves while the two-entry output queue has room
// reset: synchronous, clears valid bits, the divider side data and the output queue; other payload is not reset

module degree_trig_function_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                stall,
  input  logic [1:0]          kind,
  input  logic signed [31:0]  angle,
  output logic                result_valid,
  input  logic                result_stall,
  output logic signed [31:0]  value,
  output logic                saturated
);

  // global advance: the whole pipeline moves when the output queue has room
  logic en;

  // input stage
  logic                s0_valid;
  dtf_pkg::kind_t      s0_kind;
  logic signed [31:0]  s0_angle;

  // cosine lanes: angle and angle minus ninety degrees
  logic signed [dtf_pkg::ANG_W-1:0] ang_c;
  logic signed [dtf_pkg::ANG_W-1:0] ang_s;
  logic signed [dtf_pkg::C_W-1:0]   cv;
  logic signed [dtf_pkg::C_W-1:0]   sv;
  logic                             mvalid [dtf_pkg::COS_LAT];
  dtf_pkg::kind_t                   mkind  [dtf_pkg::COS_LAT];

  // division setup
  logic signed [dtf_pkg::C_W-1:0]   nsel;
  logic signed [dtf_pkg::C_W-1:0]   dsel;
  dtf_pkg::res_t                    dres;
  dtf_pkg::side_t                   p1_side;
  logic [dtf_pkg::D_W-1:0]          p1_n;
  logic [dtf_pkg::D_W-1:0]          p1_d;
  logic [dtf_pkg::NP_W-1:0]         np;
  dtf_pkg::side_t                   p2_side;
  logic [dtf_pkg::NP_W-1:0]         p2_np;
  logic [dtf_pkg::D_W-1:0]          p2_d;
  dtf_pkg::side_t                   side_out;
  logic [dtf_pkg::Q_W-1:0]          quo;

  // final stage and output queue
  logic [31:0]  fin_val_next;
  logic         fin_sat_next;
  logic         fin_valid;
  logic [31:0]  fin_val;
  logic         fin_sat;
  logic [1:0]   cnt;
  logic         wr_ptr;
  logic         rd_ptr;
  logic [31:0]  q_val [2];
  logic         q_sat [2];
  logic         push;
  logic         pop;

  assign en    = (cnt != 2'd2);
  assign stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_kind  <= dtf_pkg::kind_t'(kind);
      s0_angle <= angle;
    end
  end

  // sine is cosine of the angle less ninety degrees
  assign ang_c = dtf_pkg::ANG_W'(s0_angle);
  assign ang_s = ang_c - $signed(dtf_pkg::NINETY);

  dtf_cos u_cos_c (
    .clk  (clk),
    .en   (en),
    .ang  (ang_c),
    .cosv (cv)
  );

  dtf_cos u_cos_s (
    .clk  (clk),
    .en   (en),
    .ang  (ang_s),
    .cosv (sv)
  );

  // item kind and valid bit follow the cosine lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dtf_pkg::COS_LAT; i++) begin
        mvalid[i] <= 1'b0;
      end
    end else if (en) begin
      mvalid[0] <= s0_valid;
      for (int i = 1; i < dtf_pkg::COS_LAT; i++) begin
        mvalid[i] <= mvalid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mkind[0] <= s0_kind;
      for (int i = 1; i < dtf_pkg::COS_LAT; i++) begin
        mkind[i] <= mkind[i-1];
      end
    end
  end

  // pick numerator and denominator; the direct result covers cosine and sine
  assign nsel = (mkind[dtf_pkg::COS_LAT-1] == dtf_pkg::KIND_TAN) ? sv : cv;
  assign dsel = (mkind[dtf_pkg::COS_LAT-1] == dtf_pkg::KIND_TAN) ? cv : sv;
  assign dres = dtf_pkg::to_result(
                  (mkind[dtf_pkg::COS_LAT-1] == dtf_pkg::KIND_SIN) ? sv : cv);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_side.valid <= 1'b0;
    end else if (en) begin
      p1_side.valid   <= mvalid[dtf_pkg::COS_LAT-1];
      p1_side.kind    <= mkind[dtf_pkg::COS_LAT-1];
      p1_side.direct  <= dres.value;
      p1_side.dsat    <= dres.sat;
      p1_side.dz      <= (dsel == '0);
      p1_side.ovf     <= 1'b0;
      p1_side.neg     <= nsel[dtf_pkg::C_W-1] ^ dsel[dtf_pkg::C_W-1];
      p1_side.num_pos <= !nsel[dtf_pkg::C_W-1];
      p1_n <= dtf_pkg::D_W'(nsel[dtf_pkg::C_W-1] ? -nsel : nsel);
      p1_d <= dtf_pkg::D_W'(dsel[dtf_pkg::C_W-1] ? -dsel : dsel);
    end
  end

  // scaled numerator with half the divisor added, and the quotient range check
  assign np = (dtf_pkg::NP_W'(p1_n) << dtf_pkg::RFB) + dtf_pkg::NP_W'(p1_d >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_side.valid <= 1'b0;
    end else if (en) begin
      p2_side.valid   <= p1_side.valid;
      p2_side.kind    <= p1_side.kind;
      p2_side.direct  <= p1_side.direct;
      p2_side.dsat    <= p1_side.dsat;
      p2_side.dz      <= p1_side.dz;
      p2_side.ovf     <= dtf_pkg::OV_W'(np) >= (dtf_pkg::OV_W'(p1_d) << dtf_pkg::Q_W);
      p2_side.neg     <= p1_side.neg;
      p2_side.num_pos <= p1_side.num_pos;
      p2_np <= np;
      p2_d  <= p1_d;
    end
  end

  dtf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (p2_side),
    .num      (p2_np),
    .den      (p2_d),
    .side_out (side_out),
    .quo      (quo)
  );

  // result select and saturation
  always_comb begin
    fin_val_next = side_out.direct;
    fin_sat_next = side_out.dsat;
    case (side_out.kind) inside
      dtf_pkg::KIND_TAN, dtf_pkg::KIND_COT: begin
        if (side_out.dz) begin
          // zero divisor: sign of the numerator picks the end
          fin_sat_next = 1'b1;
          fin_val_next = side_out.num_pos ? dtf_pkg::OUT_MAX : dtf_pkg::OUT_MIN;
        end else if (side_out.ovf) begin
          fin_sat_next = 1'b1;
          fin_val_next = side_out.neg ? dtf_pkg::OUT_MIN : dtf_pkg::OUT_MAX;
        end else if (!side_out.neg && (quo[32] || quo[31])) begin
          fin_sat_next = 1'b1;
          fin_val_next = dtf_pkg::OUT_MAX;
        end else if (side_out.neg && (quo[32] || (quo[31] && |quo[30:0]))) begin
          fin_sat_next = 1'b1;
          fin_val_next = dtf_pkg::OUT_MIN;
        end else begin
          fin_sat_next = 1'b0;
          fin_val_next = side_out.neg ? -quo[31:0] : quo[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= side_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_val <= fin_val_next;
      fin_sat <= fin_sat_next;
    end
  end

  // two-entry output queue so the pipeline keeps moving under a short stall
  assign push = fin_valid && en;
  assign pop  = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_val[wr_ptr] <= fin_val;
      q_sat[wr_ptr] <= fin_sat;
    end
  end

  assign result_valid = (cnt != 2'd0);
  assign value        = q_val[rd_ptr];
  assign saturated    = q_sat[rd_ptr];

  // queue never overfills
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output queue count out of range");

  // a pushed item is visible in the next cycle
  a_push_seen: assert property (@(posedge clk) disable iff (rst) push |=> result_valid)
    else $error("pushed item missing from output queue");

  // a zero divisor always reports saturation
  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    (en && side_out.valid && side_out.dz &&
     (side_out.kind == dtf_pkg::KIND_TAN || side_out.kind == dtf_pkg::KIND_COT))
    |=> fin_sat)
    else $error("zero divisor without saturation");

  // a frozen pipeline keeps its final item
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(fin_valid))
    else $error("final stage changed while frozen");

endmodule
